>>> sv/kche_pkg.sv
// Shared types and constants for the key click/hold/repeat event block.
// Holds item structs, event and phase codes, and register indexes.
// No dependencies; compile first.
package kche_pkg;

	localparam int KEY_W = 5;
	localparam int TICK_W = 8;
	localparam int CFG_IDX_W = 2;

	// tally saturation point
	localparam logic [TICK_W-1:0] LONG_COUNT_MAX = 8'd250;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CLICK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 2'd2;

	// config reset values
	localparam logic [TICK_W-1:0] CLICK_RST = 8'd5;
	localparam logic [TICK_W-1:0] HOLD_RST = 8'd50;
	localparam logic [TICK_W-1:0] REPEAT_RST = 8'd20;

	typedef enum logic [2:0] {
		KIND_RELEASE = 3'd0,
		KIND_DOWN = 3'd1,
		KIND_HOLD = 3'd2,
		KIND_REPEAT = 3'd3,
		KIND_UP = 3'd4,
		KIND_LONG_UP = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DOWN = 2'd1,
		PH_HOLD = 2'd2,
		PH_REPEAT = 2'd3
	} phase_t;

	typedef struct packed {
		logic [KEY_W-1:0] sampled_key;
		logic suppress_request;
	} key_item_t;

	typedef struct packed {
		logic event_valid;
		logic [KEY_W-1:0] event_key;
		kind_t event_kind;
		logic [TICK_W-1:0] long_count;
	} evt_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [TICK_W-1:0] data;
	} cfg_write_t;

	typedef struct packed {
		logic [TICK_W-1:0] click_ticks;
		logic [TICK_W-1:0] hold_ticks;
		logic [TICK_W-1:0] repeat_ticks;
	} cfg_regs_t;

endpackage

>>> sv/kche_if.sv
// Valid/ready channel interfaces: key samples in, events out, config writes.
// Depends on kche_pkg for the payload types.
interface kche_key_if;
	import kche_pkg::*;
	logic valid;
	logic ready;
	key_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface kche_evt_if;
	import kche_pkg::*;
	logic valid;
	logic ready;
	evt_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface kche_cfg_if;
	import kche_pkg::*;
	logic valid;
	logic ready;
	cfg_write_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

>>> sv/kche_core.sv
// Key tracking state and per-tick event logic: debounce, reload counter,
// press phase, repeat tally and suppress flag. Depends on kche_pkg.
module kche_core (
	input logic clk,
	input logic arst_n,
	input logic step,
	input kche_pkg::key_item_t item,
	input kche_pkg::cfg_regs_t cfg,
	output kche_pkg::evt_item_t result
);
	import kche_pkg::*;

	logic [KEY_W-1:0] cand_q, stable_q, tracked_q;
	logic [TICK_W-1:0] reload_q, tally_q;
	phase_t phase_q;
	logic sup_q;

	logic [KEY_W-1:0] cand_d, stable_d, tracked_d;
	logic [TICK_W-1:0] reload_d, tally_d, reload_dec;
	phase_t phase_d;
	logic sup_d;
	logic fire;
	logic [KEY_W-1:0] ekey;
	kind_t kind;

	// next state for one tick
	always_comb begin
		cand_d = cand_q;
		stable_d = stable_q;
		tracked_d = tracked_q;
		reload_d = reload_q;
		tally_d = tally_q;
		phase_d = phase_q;
		sup_d = sup_q | item.suppress_request;
		fire = 1'b0;
		ekey = '0;
		kind = KIND_RELEASE;
		reload_dec = reload_q - 8'd1;

		if (stable_q != item.sampled_key) begin
			// debounce: a new code must repeat before it is taken
			if (cand_q != item.sampled_key)
				cand_d = item.sampled_key;
			else
				stable_d = item.sampled_key;
		end else if (stable_q == tracked_q) begin
			// same key held: count down to the next event
			if (tracked_q != '0 && reload_q != '0) begin
				reload_d = reload_dec;
				if (reload_dec == '0) begin
					fire = 1'b1;
					ekey = tracked_q;
					case (phase_q)
						PH_IDLE: begin
							phase_d = PH_DOWN;
							kind = KIND_DOWN;
							reload_d = cfg.hold_ticks;
						end
						PH_DOWN: begin
							phase_d = PH_HOLD;
							kind = KIND_HOLD;
							reload_d = cfg.repeat_ticks;
						end
						default: begin
							phase_d = PH_REPEAT;
							kind = KIND_REPEAT;
							reload_d = cfg.repeat_ticks;
							if (tally_q < LONG_COUNT_MAX)
								tally_d = tally_q + 8'd1;
						end
					endcase
				end
			end
		end else begin
			// stable key changed: close out the old tracked key
			if (tracked_q != '0) begin
				fire = 1'b1;
				ekey = tracked_q;
				case (phase_q)
					PH_IDLE: kind = KIND_RELEASE;
					PH_DOWN: kind = KIND_UP;
					default: kind = KIND_LONG_UP;
				endcase
				phase_d = PH_IDLE;
			end else begin
				sup_d = 1'b0;
				tally_d = '0;
			end
			reload_d = cfg.click_ticks;
			tracked_d = stable_q;
		end

		result.event_valid = fire & ~sup_d;
		result.event_key = (fire & ~sup_d) ? ekey : '0;
		result.event_kind = (fire & ~sup_d) ? kind : KIND_RELEASE;
		result.long_count = tally_d;
	end

	// state registers advance once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
			stable_q <= '0;
			tracked_q <= '0;
			reload_q <= '0;
			tally_q <= '0;
			phase_q <= PH_IDLE;
			sup_q <= 1'b0;
		end else if (step) begin
			cand_q <= cand_d;
			stable_q <= stable_d;
			tracked_q <= tracked_d;
			reload_q <= reload_d;
			tally_q <= tally_d;
			phase_q <= phase_d;
			sup_q <= sup_d;
		end
	end

endmodule

>>> sv/key_click_hold_repeat_events.sv
// Key event generator: takes one sampled key code per beat on keys and
// returns exactly one result beat on events, carrying down, hold, repeat and
// release events plus the saturating repeat tally. A beat is accepted every
// clock cycle; its result is captured into the output register. The
// only stall is that output register: keys.ready drops while it holds a
// result that events has not taken. Config writes on cfg are taken at once.
// Depends on kche_pkg, kche_if and kche_core.
module key_click_hold_repeat_events (
	input logic clk,
	input logic arst_n,
	kche_key_if.sink keys,
	kche_evt_if.source events,
	kche_cfg_if.sink cfg
);
	import kche_pkg::*;

	cfg_regs_t regs_q;
	evt_item_t result;
	evt_item_t out_q;
	logic out_valid_q;
	logic step;

	// config register file
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.click_ticks <= CLICK_RST;
			regs_q.hold_ticks <= HOLD_RST;
			regs_q.repeat_ticks <= REPEAT_RST;
		end else if (cfg.valid) begin
			case (cfg.payload.index)
				REG_CLICK: regs_q.click_ticks <= cfg.payload.data;
				REG_HOLD: regs_q.hold_ticks <= cfg.payload.data;
				REG_REPEAT: regs_q.repeat_ticks <= cfg.payload.data;
				default: ;
			endcase
		end
	end

	// input handshake: accept while the output slot is free or draining
	assign keys.ready = !out_valid_q || events.ready;
	assign step = keys.valid && keys.ready;

	kche_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.item(keys.payload),
		.cfg(regs_q),
		.result(result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step)
			out_valid_q <= 1'b1;
		else if (events.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step)
			out_q <= result;
	end

	assign events.valid = out_valid_q;
	assign events.payload = out_q;

	// checks
	a_tally_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.long_count <= LONG_COUNT_MAX)
		else $error("repeat tally above saturation");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.event_valid) |->
			(out_q.event_key == '0 && out_q.event_kind == KIND_RELEASE))
		else $error("no-event result carries key or kind");

	a_event_key: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.event_valid) |-> out_q.event_key != '0)
		else $error("event reported for no key");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !events.ready) |-> !keys.ready)
		else $error("input accepted while result is stalled");

endmodule
